[hw/rtl/irbn_pkg.sv]
package irbn_pkg;

    // frame store geometry and fixed-point format
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 16;

    // field widths
    localparam int COORD_W = 12;
    localparam int STEP_W  = 20;
    localparam int DIM_W   = 10;
    localparam int PIX_W   = 8;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 20;

    // derived widths
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int IDX_W      = (ROW_W > COL_W) ? ROW_W : COL_W;
    localparam int POS_W      = COORD_W + STEP_W;
    localparam int INT_W      = POS_W - FRAC_BITS;
    localparam int WGT_W      = FRAC_BITS + 1;
    localparam int BANK_AW    = ROW_W + COL_W - 2;
    localparam int BANK_DEPTH = 2 ** BANK_AW;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } t_op;

    typedef enum logic {
        MODE_NEAREST  = 1'b0,
        MODE_BILINEAR = 1'b1
    } t_mode;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_SRC_HEIGHT  = 3'd1,
        CFG_ROW_STEP    = 3'd2,
        CFG_COL_STEP    = 3'd3,
        CFG_INTERP_MODE = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [DIM_W-1:0]  src_width;
        logic [DIM_W-1:0]  src_height;
        logic [STEP_W-1:0] row_step;
        logic [STEP_W-1:0] col_step;
        t_mode             mode;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [PIX_W-1:0]   pixel;
    } t_item;

    // neighbour indices and weights, plus write target
    typedef struct packed {
        t_op                  op;
        logic                 wr_ok;
        logic [ROW_W-1:0]     wrow;
        logic [COL_W-1:0]     wcol;
        logic [PIX_W-1:0]     pixel;
        logic [ROW_W-1:0]     r0;
        logic [ROW_W-1:0]     r1;
        logic [COL_W-1:0]     c0;
        logic [COL_W-1:0]     c1;
        logic [FRAC_BITS-1:0] fr;
        logic [FRAC_BITS-1:0] fc;
    } t_lookup;

    // four bank words and the bank parity of each neighbour
    typedef struct packed {
        logic [3:0][PIX_W-1:0] q;
        logic                  r0p;
        logic                  r1p;
        logic                  c0p;
        logic                  c1p;
        logic [FRAC_BITS-1:0]  fr;
        logic [FRAC_BITS-1:0]  fc;
    } t_fetch;

    // zero acts as one, above the maximum acts as the maximum
    function automatic logic [IDX_W:0] eff_dim(input logic [DIM_W-1:0] v, input int maxv);
        logic [IDX_W:0] res;
        if (v == '0) begin
            res = (IDX_W+1)'(1);
        end else if (int'(v) > maxv) begin
            res = (IDX_W+1)'(maxv);
        end else begin
            res = (IDX_W+1)'(v);
        end
        return res;
    endfunction

    // clamp an index to the last row or column
    function automatic logic [IDX_W-1:0] clamp_idx(input logic [INT_W:0] i,
                                                   input logic [IDX_W:0] lim);
        logic [IDX_W:0]   last;
        logic [IDX_W-1:0] res;
        last = lim - 1'b1;
        if (i >= (INT_W+1)'(lim)) begin
            res = last[IDX_W-1:0];
        end else begin
            res = i[IDX_W-1:0];
        end
        return res;
    endfunction

endpackage

[hw/rtl/irbn_pos.sv]
module irbn_pos (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  irbn_pkg::t_item  i_item,
    input  irbn_pkg::t_cfg   i_cfg,
    output logic             o_valid,
    output irbn_pkg::t_lookup o_lkp
);
    import irbn_pkg::*;

    localparam logic [POS_W:0] HALF = (POS_W+1)'(1) << (FRAC_BITS - 1);

    logic             r_a_valid;
    t_item            r_a_item;
    logic [POS_W-1:0] r_rpos;
    logic [POS_W-1:0] r_cpos;

    logic             r_b_valid;
    t_lookup          r_b;
    t_lookup          n_b;

    logic [POS_W:0]   rsum;
    logic [POS_W:0]   csum;
    logic [INT_W:0]   rnear;
    logic [INT_W:0]   cnear;
    logic [INT_W:0]   rlo;
    logic [INT_W:0]   rhi;
    logic [INT_W:0]   clo;
    logic [INT_W:0]   chi;
    logic [IDX_W:0]   eff_w;
    logic [IDX_W:0]   eff_h;
    logic [IDX_W-1:0] rn_i;
    logic [IDX_W-1:0] cn_i;
    logic [IDX_W-1:0] r0_i;
    logic [IDX_W-1:0] r1_i;
    logic [IDX_W-1:0] c0_i;
    logic [IDX_W-1:0] c1_i;

    // stage a: scale output coordinates to source positions
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_item <= i_item;
            r_rpos   <= i_item.row * i_cfg.row_step;
            r_cpos   <= i_item.col * i_cfg.col_step;
        end
    end

    // stage b: integer parts, rounding and edge clamp
    always_comb begin
        rsum  = {1'b0, r_rpos} + HALF;
        csum  = {1'b0, r_cpos} + HALF;
        rnear = rsum[POS_W:FRAC_BITS];
        cnear = csum[POS_W:FRAC_BITS];
        rlo   = {1'b0, r_rpos[POS_W-1:FRAC_BITS]};
        clo   = {1'b0, r_cpos[POS_W-1:FRAC_BITS]};
        rhi   = rlo + 1'b1;
        chi   = clo + 1'b1;
        eff_w = eff_dim(i_cfg.src_width, MAX_WIDTH);
        eff_h = eff_dim(i_cfg.src_height, MAX_HEIGHT);
        rn_i  = clamp_idx(rnear, eff_h);
        cn_i  = clamp_idx(cnear, eff_w);
        r0_i  = clamp_idx(rlo, eff_h);
        r1_i  = clamp_idx(rhi, eff_h);
        c0_i  = clamp_idx(clo, eff_w);
        c1_i  = clamp_idx(chi, eff_w);

        n_b.op    = r_a_item.op;
        n_b.wr_ok = (int'(r_a_item.row) < MAX_HEIGHT) && (int'(r_a_item.col) < MAX_WIDTH);
        n_b.wrow  = r_a_item.row[ROW_W-1:0];
        n_b.wcol  = r_a_item.col[COL_W-1:0];
        n_b.pixel = r_a_item.pixel;
        // nearest reads one pixel at full weight
        if (i_cfg.mode == MODE_NEAREST) begin
            n_b.r0 = rn_i[ROW_W-1:0];
            n_b.r1 = rn_i[ROW_W-1:0];
            n_b.c0 = cn_i[COL_W-1:0];
            n_b.c1 = cn_i[COL_W-1:0];
            n_b.fr = '0;
            n_b.fc = '0;
        end else begin
            n_b.r0 = r0_i[ROW_W-1:0];
            n_b.r1 = r1_i[ROW_W-1:0];
            n_b.c0 = c0_i[COL_W-1:0];
            n_b.c1 = c1_i[COL_W-1:0];
            n_b.fr = r_rpos[FRAC_BITS-1:0];
            n_b.fc = r_cpos[FRAC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b <= n_b;
        end
    end

    assign o_valid = r_b_valid;
    assign o_lkp   = r_b;

endmodule

[hw/rtl/irbn_store.sv]
module irbn_store (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  irbn_pkg::t_lookup i_lkp,
    output logic              o_valid,
    output irbn_pkg::t_fetch  o_fetch
);
    import irbn_pkg::*;

    logic                 r_valid;
    logic                 r_r0p;
    logic                 r_r1p;
    logic                 r_c0p;
    logic                 r_c1p;
    logic [FRAC_BITS-1:0] r_fr;
    logic [FRAC_BITS-1:0] r_fc;
    wire  [3:0][PIX_W-1:0] q_all;

    // only reads go on to the blend stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && (i_lkp.op == OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r0p <= i_lkp.r0[0];
            r_r1p <= i_lkp.r1[0];
            r_c0p <= i_lkp.c0[0];
            r_c1p <= i_lkp.c1[0];
            r_fr  <= i_lkp.fr;
            r_fc  <= i_lkp.fc;
        end
    end

    // four banks split by row and column parity
    for (genvar b = 0; b < 4; b++) begin : g_bank
        localparam logic PR = 1'(b >> 1);
        localparam logic PC = 1'(b);

        logic [PIX_W-1:0]   r_bank [BANK_DEPTH];
        logic [PIX_W-1:0]   r_q;
        logic [ROW_W-1:0]   rsel;
        logic [COL_W-1:0]   csel;
        logic [BANK_AW-1:0] raddr;
        logic [BANK_AW-1:0] waddr;
        logic               we;

        // the neighbour whose parity matches this bank
        assign rsel  = (i_lkp.r0[0] == PR) ? i_lkp.r0 : i_lkp.r1;
        assign csel  = (i_lkp.c0[0] == PC) ? i_lkp.c0 : i_lkp.c1;
        assign raddr = {rsel[ROW_W-1:1], csel[COL_W-1:1]};
        assign waddr = {i_lkp.wrow[ROW_W-1:1], i_lkp.wcol[COL_W-1:1]};
        assign we    = i_en && i_valid && (i_lkp.op == OP_WRITE) && i_lkp.wr_ok
                    && (i_lkp.wrow[0] == PR) && (i_lkp.wcol[0] == PC);

        always_ff @(posedge i_clk) begin
            if (we) begin
                r_bank[waddr] <= i_lkp.pixel;
            end
            if (i_en) begin
                r_q <= r_bank[raddr];
            end
        end

        assign q_all[b] = r_q;
    end

    assign o_valid     = r_valid;
    assign o_fetch.q   = q_all;
    assign o_fetch.r0p = r_r0p;
    assign o_fetch.r1p = r_r1p;
    assign o_fetch.c0p = r_c0p;
    assign o_fetch.c1p = r_c1p;
    assign o_fetch.fr  = r_fr;
    assign o_fetch.fc  = r_fc;

endmodule

[hw/rtl/irbn_blend.sv]
module irbn_blend (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  irbn_pkg::t_fetch            i_fetch,
    output logic                        o_valid,
    output logic [irbn_pkg::PIX_W-1:0]  o_pixel
);
    import irbn_pkg::*;

    localparam int HW = PIX_W + FRAC_BITS;
    localparam int AW = PIX_W + 2 * FRAC_BITS + 1;
    localparam logic [WGT_W-1:0] ONE = WGT_W'(1) << FRAC_BITS;

    logic [PIX_W-1:0]     p00;
    logic [PIX_W-1:0]     p01;
    logic [PIX_W-1:0]     p10;
    logic [PIX_W-1:0]     p11;
    logic [WGT_W-1:0]     wc0;
    logic [WGT_W-1:0]     wc1;
    logic [HW:0]          s0;
    logic [HW:0]          s1;
    logic                 r_c_valid;
    logic [HW-1:0]        r_t0;
    logic [HW-1:0]        r_t1;
    logic [FRAC_BITS-1:0] r_fr;
    logic [WGT_W-1:0]     wr0;
    logic [WGT_W-1:0]     wr1;
    logic [AW-1:0]        acc;
    logic                 r_d_valid;
    logic [PIX_W-1:0]     r_pixel;

    // stage c: pick neighbours by bank parity, blend along columns
    always_comb begin
        p00 = i_fetch.q[{i_fetch.r0p, i_fetch.c0p}];
        p01 = i_fetch.q[{i_fetch.r0p, i_fetch.c1p}];
        p10 = i_fetch.q[{i_fetch.r1p, i_fetch.c0p}];
        p11 = i_fetch.q[{i_fetch.r1p, i_fetch.c1p}];
        wc1 = {1'b0, i_fetch.fc};
        wc0 = ONE - wc1;
        s0  = p00 * wc0 + p01 * wc1;
        s1  = p10 * wc0 + p11 * wc1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_en) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0 <= s0[HW-1:0];
            r_t1 <= s1[HW-1:0];
            r_fr <= i_fetch.fr;
        end
    end

    // stage d: blend along rows and floor to a pixel
    always_comb begin
        wr1 = {1'b0, r_fr};
        wr0 = ONE - wr1;
        acc = r_t0 * wr0 + r_t1 * wr1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= acc[2*FRAC_BITS+PIX_W-1:2*FRAC_BITS];
        end
    end

    assign o_valid = r_d_valid;
    assign o_pixel = r_pixel;

endmodule

[hw/rtl/image_resample_bilinear_nearest.sv]
// read path: a read transfer goes through stages a, b, store, c and d in order before its pixel shows
// throughput: one item per cycle when not stalled, writes and reads mixed freely, set by the five-stage pipeline
// a stalled output freezes every stage; no bubble is squeezed out and nothing is lost
// reset: synchronous active-low; clears all stage valids and loads the register defaults
// the frame store is not cleared by reset; a pixel reads as garbage until written
module image_resample_bilinear_nearest (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [irbn_pkg::COORD_W-1:0]  i_row,
    input  logic [irbn_pkg::COORD_W-1:0]  i_col,
    input  logic [irbn_pkg::PIX_W-1:0]    i_pixel_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [irbn_pkg::PIX_W-1:0]    o_pixel_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [irbn_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [irbn_pkg::CFG_DW-1:0]   i_cfg_data
);
    import irbn_pkg::*;

    t_cfg    r_cfg;
    t_item   item;
    logic    en;
    logic    lkp_valid;
    t_lookup lkp;
    logic    fetch_valid;
    t_fetch  fetch;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= DIM_W'(512);
            r_cfg.src_height <= DIM_W'(512);
            r_cfg.row_step   <= STEP_W'(65536);
            r_cfg.col_step   <= STEP_W'(65536);
            r_cfg.mode       <= MODE_BILINEAR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:   r_cfg.src_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SRC_HEIGHT:  r_cfg.src_height <= i_cfg_data[DIM_W-1:0];
                CFG_ROW_STEP:    r_cfg.row_step   <= i_cfg_data[STEP_W-1:0];
                CFG_COL_STEP:    r_cfg.col_step   <= i_cfg_data[STEP_W-1:0];
                CFG_INTERP_MODE: r_cfg.mode       <= t_mode'(i_cfg_data[0]);
                default: ;
            endcase
        end
    end

    // whole pipeline moves unless a finished pixel is held
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    assign item.op    = t_op'(i_op);
    assign item.row   = i_row;
    assign item.col   = i_col;
    assign item.pixel = i_pixel_in;

    irbn_pos u_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .o_valid (lkp_valid),
        .o_lkp   (lkp)
    );

    irbn_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lkp_valid),
        .i_lkp   (lkp),
        .o_valid (fetch_valid),
        .o_fetch (fetch)
    );

    irbn_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (fetch_valid),
        .i_fetch (fetch),
        .o_valid (o_valid),
        .o_pixel (o_pixel_out)
    );

`ifndef SYNTHESIS
    // banking needs the second row and column at most one past the first
    a_row_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lkp_valid |-> (lkp.r1 >= lkp.r0) && ((lkp.r1 - lkp.r0) <= 1))
        else $error("row neighbours too far apart");

    a_col_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lkp_valid |-> (lkp.c1 >= lkp.c0) && ((lkp.c1 - lkp.c0) <= 1))
        else $error("column neighbours too far apart");

    // nearest mode carries one pixel at full weight
    a_nearest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lkp_valid && (r_cfg.mode == MODE_NEAREST))
            |-> (lkp.fr == '0) && (lkp.fc == '0) && (lkp.r0 == lkp.r1) && (lkp.c0 == lkp.c1))
        else $error("nearest lookup with fractional weight");

    // reset empties the output stage
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
